[src/date_string_to_packed_date_defines.svh]
// Assertion helpers used by the checker file.
`ifndef DATE_STRING_TO_PACKED_DATE_DEFINES_SVH
`define DATE_STRING_TO_PACKED_DATE_DEFINES_SVH

// Check a property on every rising clock edge outside reset.
`define DS2PD_CHECK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define DS2PD_CHECK_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[src/ds2pd_pkg.sv]
package ds2pd_pkg;

	typedef enum logic [1:0] {
		CW_DIGIT,
		CW_SEP,
		CW_TERM
	} char_kind_t;

	// One classified character word handed from the front to the back.
	typedef struct packed {
		char_kind_t  kind;
		logic [3:0]  digit;
		logic        empty;
	} char_word_t;

	localparam logic [7:0] CHAR_ZERO = 8'h30;
	localparam logic [7:0] CHAR_NINE = 8'h39;

	localparam logic [13:0] TOKEN_MAX   = 14'd9999;
	localparam logic [14:0] YEAR_BASE   = 15'd1900;
	localparam logic [14:0] YEAR_LAST   = 15'd5995;
	localparam logic [13:0] MONTH_LAST  = 14'd12;
	localparam logic [13:0] DAY_LAST    = 14'd31;
	localparam logic [2:0]  DIGITS_FULL = 3'd4;

endpackage

[src/ds2pd_front.sv]
module ds2pd_front #(
	parameter int MAX_CHARS = 63
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [7:0]            char_code,
	output logic                  push_valid,
	input  logic                  push_ready,
	output ds2pd_pkg::char_word_t push_word
);

	localparam int PW = $clog2(MAX_CHARS + 1);

	logic [PW-1:0] pos_q;
	logic          is_term;
	logic          room;
	logic          accept;

	assign is_term = (char_code == 8'd0);
	assign room    = (pos_q < PW'(MAX_CHARS));
	assign in_ready   = push_ready;
	// drop characters beyond the length limit, keep the terminator
	assign push_valid = in_valid && (is_term || room);
	assign accept     = in_valid && in_ready;

	always_comb begin
		push_word.digit = 4'(char_code - ds2pd_pkg::CHAR_ZERO);
		push_word.empty = (pos_q == '0);
		if (is_term) begin
			push_word.kind = ds2pd_pkg::CW_TERM;
		end else if (char_code >= ds2pd_pkg::CHAR_ZERO && char_code <= ds2pd_pkg::CHAR_NINE) begin
			push_word.kind = ds2pd_pkg::CW_DIGIT;
		end else begin
			push_word.kind = ds2pd_pkg::CW_SEP;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (accept) begin
			if (is_term) begin
				pos_q <= '0;
			end else if (room) begin
				pos_q <= pos_q + 1'b1;
			end
		end
	end

endmodule

[src/ds2pd_queue.sv]
module ds2pd_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push_valid,
	output logic                  push_ready,
	input  ds2pd_pkg::char_word_t push_word,
	output logic                  pop_valid,
	input  logic                  pop_ready,
	output ds2pd_pkg::char_word_t pop_word
);

	localparam int DEPTH = 2;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = $clog2(DEPTH + 1);

	ds2pd_pkg::char_word_t mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          push;
	logic          pop;

	assign push_ready = (count_q != CW'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_word   = mem_q[rd_ptr_q];
	assign push = push_valid && push_ready;
	assign pop  = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[src/ds2pd_back.sv]
module ds2pd_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  pop_valid,
	output logic                  pop_ready,
	input  ds2pd_pkg::char_word_t pop_word,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [31:0]           packed_date,
	output logic                  bad_date
);

	localparam logic [2:0] PH_PRE_YEAR  = 3'd0;
	localparam logic [2:0] PH_YEAR      = 3'd1;
	localparam logic [2:0] PH_PRE_MONTH = 3'd2;
	localparam logic [2:0] PH_MONTH     = 3'd3;
	localparam logic [2:0] PH_PRE_DAY   = 3'd4;
	localparam logic [2:0] PH_DAY       = 3'd5;
	localparam logic [2:0] PH_DONE      = 3'd6;

	logic [2:0]  phase_q;
	logic [2:0]  dcount_q;
	logic [13:0] token_q;
	logic [11:0] year_q;   // year minus 1900
	logic [3:0]  month_q;  // month minus one
	logic [4:0]  day_q;
	logic        invalid_q;
	logic        out_valid_q;
	logic [31:0] packed_q;
	logic        bad_q;

	logic        take;
	logic [17:0] tok_x10;
	logic [13:0] tok_next;
	logic [2:0]  dcount_next;
	logic [14:0] year_full;
	logic [14:0] year_rel;
	logic        year_ok;
	logic        month_ok;
	logic        day_ok;
	logic [2:0]  cl_phase;
	logic [11:0] cl_year;
	logic [3:0]  cl_month;
	logic [4:0]  cl_day;
	logic        cl_invalid;
	logic        end_invalid;

	assign out_valid   = out_valid_q;
	assign packed_date = packed_q;
	assign bad_date    = bad_q;

	// a terminator waits until the output register is free
	assign pop_ready = (pop_word.kind != ds2pd_pkg::CW_TERM) || !out_valid_q || out_ready;
	assign take      = pop_valid && pop_ready;

	assign tok_x10     = {1'b0, token_q, 3'b000} + {3'b000, token_q, 1'b0}
	                   + {14'd0, pop_word.digit};
	assign tok_next    = (tok_x10 > {4'd0, ds2pd_pkg::TOKEN_MAX}) ?
	                     ds2pd_pkg::TOKEN_MAX : tok_x10[13:0];
	assign dcount_next = (dcount_q < ds2pd_pkg::DIGITS_FULL) ? dcount_q + 1'b1 : dcount_q;

	// short years are taken as offsets from 1900
	assign year_full = {1'b0, token_q}
	                 + ((dcount_q < ds2pd_pkg::DIGITS_FULL) ? ds2pd_pkg::YEAR_BASE : 15'd0);
	assign year_rel  = year_full - ds2pd_pkg::YEAR_BASE;
	assign year_ok   = (year_full >= ds2pd_pkg::YEAR_BASE) && (year_full <= ds2pd_pkg::YEAR_LAST);
	assign month_ok  = (token_q != '0) && (token_q <= ds2pd_pkg::MONTH_LAST);
	assign day_ok    = (token_q != '0) && (token_q <= ds2pd_pkg::DAY_LAST);

	// close the digit run in progress
	always_comb begin
		cl_phase   = phase_q;
		cl_year    = year_q;
		cl_month   = month_q;
		cl_day     = day_q;
		cl_invalid = invalid_q;
		unique case (phase_q)
			PH_YEAR: begin
				if (year_ok) begin
					cl_year  = year_rel[11:0];
					cl_phase = PH_PRE_MONTH;
				end else begin
					cl_invalid = 1'b1;
					cl_phase   = PH_DONE;
				end
			end
			PH_MONTH: begin
				if (month_ok) begin
					cl_month = 4'(token_q - 14'd1);
					cl_phase = PH_PRE_DAY;
				end else begin
					cl_invalid = 1'b1;
					cl_phase   = PH_DONE;
				end
			end
			PH_DAY: begin
				if (day_ok) begin
					cl_day = token_q[4:0];
				end else begin
					cl_invalid = 1'b1;
				end
				cl_phase = PH_DONE;
			end
			default: begin
			end
		endcase
	end

	assign end_invalid = (phase_q == PH_PRE_YEAR) ? 1'b1 : cl_invalid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_PRE_YEAR;
			dcount_q  <= '0;
			token_q   <= '0;
			year_q    <= '0;
			month_q   <= '0;
			day_q     <= 5'd1;
			invalid_q <= 1'b0;
		end else if (take) begin
			case (pop_word.kind)
				ds2pd_pkg::CW_DIGIT: begin
					if (phase_q != PH_DONE) begin
						unique case (phase_q) inside
							PH_PRE_YEAR, PH_PRE_MONTH, PH_PRE_DAY: phase_q <= phase_q + 1'b1;
							default: begin
							end
						endcase
						token_q  <= tok_next;
						dcount_q <= dcount_next;
					end
				end
				ds2pd_pkg::CW_SEP: begin
					phase_q   <= cl_phase;
					year_q    <= cl_year;
					month_q   <= cl_month;
					day_q     <= cl_day;
					invalid_q <= cl_invalid;
					token_q   <= '0;
					dcount_q  <= '0;
				end
				default: begin
					// terminator: return to the start state
					phase_q   <= PH_PRE_YEAR;
					dcount_q  <= '0;
					token_q   <= '0;
					year_q    <= '0;
					month_q   <= '0;
					day_q     <= 5'd1;
					invalid_q <= 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take && pop_word.kind == ds2pd_pkg::CW_TERM) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && pop_word.kind == ds2pd_pkg::CW_TERM) begin
			if (pop_word.empty) begin
				packed_q <= '0;
				bad_q    <= 1'b0;
			end else if (end_invalid) begin
				packed_q <= '1;
				bad_q    <= 1'b1;
			end else begin
				packed_q <= {cl_year, cl_month, cl_day, 11'd0};
				bad_q    <= 1'b0;
			end
		end
	end

endmodule

[src/date_string_to_packed_date.sv]
// Date string to packed date word.
// Input channel (in_valid, in_ready, char_code): one string byte per word.
// A zero byte ends the string; only it produces a result word on the
// output channel (out_valid, out_ready, packed_date, bad_date).
// Bytes after the first MAX_CHARS of a string are dropped up to the zero.
// Result: (year-1900)<<20 | (month-1)<<16 | day<<11; 0 for an empty string;
// all ones with bad_date set when there are no digits or a field is out of
// range.
// Throughput: one byte per cycle while the queue has room; the front
// classifies, a two-word queue feeds the back, and the back updates its
// parse state on each word it takes. A zero byte waits in the queue behind
// any words ahead of it; its result is then held in the output register.
// When the receiver stalls, the result holds in the output register; the
// back keeps taking bytes of the next string and the next zero byte waits
// in the queue, so input stalls only once the queue fills.
// Reset clears the queue, the parse state and the output valid at once;
// the block is ready for bytes as soon as reset is released.
module date_string_to_packed_date #(
	parameter int MAX_CHARS = 63
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  char_code,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] packed_date,
	output logic        bad_date
);

	logic                  push_valid;
	logic                  push_ready;
	ds2pd_pkg::char_word_t push_word;
	logic                  pop_valid;
	logic                  pop_ready;
	ds2pd_pkg::char_word_t pop_word;

	ds2pd_front #(
		.MAX_CHARS(MAX_CHARS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.char_code  (char_code),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_word  (push_word)
	);

	ds2pd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_word  (push_word),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_word   (pop_word)
	);

	ds2pd_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.pop_valid   (pop_valid),
		.pop_ready   (pop_ready),
		.pop_word    (pop_word),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.packed_date (packed_date),
		.bad_date    (bad_date)
	);

endmodule

[src/ds2pd_checker.sv]
`include "date_string_to_packed_date_defines.svh"

module ds2pd_sva (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] packed_date,
	input logic        bad_date
);

	`DS2PD_CHECK(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(packed_date) && $stable(bad_date), "result word changed while stalled")
	`DS2PD_CHECK(a_bad_all_ones, out_valid && bad_date |-> packed_date == 32'hFFFFFFFF, "bad date without all ones")
	`DS2PD_CHECK(a_low_bits_zero, out_valid && !bad_date |-> packed_date[10:0] == 11'd0, "low bits set in good date")
	`DS2PD_CHECK(a_fields_legal, out_valid && !bad_date && packed_date != 32'd0 |-> packed_date[15:11] != 5'd0 && packed_date[19:16] <= 4'd11, "day or month out of range")
	`DS2PD_CHECK_ALWAYS(a_reset_idle, !arst_n |-> !out_valid, "result valid during reset")

endmodule

bind date_string_to_packed_date ds2pd_sva u_checker (.*);
